FILE: hw/rtl/gn3_pkg.sv
// Shared types, constants and field layout for the 3D gradient noise block.
package gn3_pkg;

    localparam int TABLE_SIZE_DEF = 256;

    localparam int COORD_W   = 32;
    localparam int GRAD_W    = 16;
    localparam int FRAC_W    = 16;
    localparam int PERM_W    = 8;
    localparam int TIDX_W    = 8;
    localparam int DOT_W     = 20;
    localparam int DIFF_W    = 21;
    localparam int NOISE_W   = 20;
    localparam int SUM_W     = 40;
    localparam int ACC_W     = 35;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 19;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int POLY_W    = 18;
    localparam int SHIFT_W   = 4;

    localparam int FADE_THREE = 3 * (2 ** FRAC_W);
    localparam int OUT_MAX    = 524287;
    localparam int OUT_MIN    = -524288;

    localparam int IN_DATA_W  = 160;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    localparam int TIDX_OFS = 0;
    localparam int PERM_OFS = 8;
    localparam int GX_OFS   = 16;
    localparam int GY_OFS   = 32;
    localparam int GZ_OFS   = 48;
    localparam int CX_OFS   = 64;
    localparam int CY_OFS   = 96;
    localparam int CZ_OFS   = 128;

    localparam logic [2:0] PERM_LAST  = 3'd6;
    localparam logic [2:0] FADE_LAST  = 3'd5;
    localparam logic [2:0] DOT_LAST   = 3'd3;
    localparam logic [2:0] LERP_LAST  = 3'd1;
    localparam logic [2:0] LAST_CORNER = 3'd7;
    localparam logic [1:0] TOP_LEVEL  = 2'd2;

    localparam logic CFG_TURB = 1'b0;
    localparam logic CFG_TOP  = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD_PERM = 2'd0,
        OP_LOAD_GRAD = 2'd1,
        OP_EVAL      = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_START,
        CMD_SPLIT,
        CMD_PERM,
        CMD_FADE,
        CMD_GADDR,
        CMD_DOT,
        CMD_LERP,
        CMD_ACC,
        CMD_OUT
    } cmd_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPLIT,
        S_PERM,
        S_FADE,
        S_GADDR,
        S_DOT,
        S_LERP,
        S_ACC,
        S_OUT
    } state_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [2:0] step;
        logic [2:0] corner;
        logic [1:0] level;
        logic       perm_we;
        logic       grad_we;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_octave;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic               turb;
        logic [SHIFT_W-1:0] top;
    } cfg_t;

endpackage

FILE: hw/rtl/gn3_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gn3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/gn3_ctrl.sv
// Sequencing state machine for the 3D gradient noise block.
module gn3_ctrl
    import gn3_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [IN_USER_W-1:0] in_user,
    output logic                 in_ready,
    input  dp_status_t           status,
    output ctrl_cmd_t            cmd
);

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic [2:0] corner_reg, corner_next;
    logic [1:0] level_reg, level_next;
    logic       more_lerp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            corner_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            corner_reg <= corner_next;
            level_reg  <= level_next;
        end
    end

    always_comb
    begin
        unique case (level_reg)
            2'd0:    more_lerp = corner_reg[1];
            2'd1:    more_lerp = corner_reg[2];
            default: more_lerp = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        corner_next = corner_reg;
        level_next  = level_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_user == OP_EVAL)
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                state_next = S_PERM;
                step_next  = '0;
            end
            S_PERM:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == PERM_LAST)
                begin
                    state_next = S_FADE;
                    step_next  = '0;
                end
            end
            S_FADE:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == FADE_LAST)
                begin
                    state_next  = S_GADDR;
                    corner_next = '0;
                end
            end
            S_GADDR:
            begin
                state_next = S_DOT;
                step_next  = '0;
            end
            S_DOT:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == DOT_LAST)
                begin
                    step_next = '0;
                    if (corner_reg[0])
                    begin
                        state_next = S_LERP;
                        level_next = '0;
                    end
                    else
                    begin
                        state_next  = S_GADDR;
                        corner_next = corner_reg + 3'd1;
                    end
                end
            end
            S_LERP:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == LERP_LAST)
                begin
                    step_next = '0;
                    if (level_reg < TOP_LEVEL && more_lerp)
                    begin
                        level_next = level_reg + 2'd1;
                    end
                    else if (corner_reg == LAST_CORNER)
                    begin
                        state_next = S_ACC;
                    end
                    else
                    begin
                        state_next  = S_GADDR;
                        corner_next = corner_reg + 3'd1;
                    end
                end
            end
            S_ACC:
            begin
                state_next = status.last_octave ? S_OUT : S_SPLIT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.op      = CMD_IDLE;
        cmd.step    = step_reg;
        cmd.corner  = corner_reg;
        cmd.level   = level_reg;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.perm_we = in_valid && in_user == OP_LOAD_PERM;
                cmd.grad_we = in_valid && in_user == OP_LOAD_GRAD;
                if (in_valid && in_user == OP_EVAL)
                begin
                    cmd.op = CMD_START;
                end
            end
            S_SPLIT: cmd.op = CMD_SPLIT;
            S_PERM:  cmd.op = CMD_PERM;
            S_FADE:  cmd.op = CMD_FADE;
            S_GADDR: cmd.op = CMD_GADDR;
            S_DOT:   cmd.op = CMD_DOT;
            S_LERP:  cmd.op = CMD_LERP;
            S_ACC:   cmd.op = CMD_ACC;
            S_OUT:   cmd.op = status.out_free ? CMD_OUT : CMD_IDLE;
            default: cmd.op = CMD_IDLE;
        endcase
    end

endmodule

FILE: hw/rtl/gn3_dpath.sv
// Datapath of the 3D gradient noise block: tables, shared multiplier, blend stack.
module gn3_dpath
    import gn3_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  cfg_t                  cfg,
    input  logic [IN_DATA_W-1:0]  in_data,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_valid,
    input  logic                  out_ready
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(OUT_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(OUT_MIN);

    logic signed [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [SHIFT_W-1:0]        k_reg, top_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [IDX_W-1:0]          x0_reg, y0_reg, z0_reg;
    logic [FRAC_W-1:0]         fx_reg, fy_reg, fz_reg;
    logic [IDX_W-1:0]          hi_reg, hj_reg, h00_reg, h10_reg, h01_reg, h11_reg;
    logic [FRAC_W-1:0]         sx_reg, sy_reg, sz_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [DOT_W-1:0]   st_reg [4];
    logic [NOISE_W-1:0]        out_reg;
    logic                      out_valid_reg;

    logic signed [COORD_W-1:0] shx, shy, shz;
    logic [IDX_W-1:0]          perm_raddr, grad_raddr, hsel, zsel, tbl_waddr;
    logic                      perm_re;
    logic [PERM_W-1:0]         perm_rdata;
    logic [3*GRAD_W-1:0]       grad_rdata;
    logic [IDX_W-1:0]          perm_idx;
    logic [FRAC_W-1:0]         fsel, ssel;
    logic [POLY_W-1:0]         poly;
    logic signed [FRAC_W:0]    rx, ry, rz;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [ACC_W-1:0]   dot_sum;
    logic signed [DIFF_W-1:0]  diff, lerp_sum;
    logic signed [SUM_W-1:0]   sum_sh;

    assign tbl_waddr = IDX_W'(in_data[TIDX_OFS +: TIDX_W]);
    assign perm_idx  = IDX_W'(perm_rdata);

    gn3_ram #(
        .WIDTH (PERM_W),
        .DEPTH (TABLE_SIZE)
    ) u_perm_ram (
        .clk     (clk),
        .we      (cmd.perm_we),
        .wr_addr (tbl_waddr),
        .wr_data (in_data[PERM_OFS +: PERM_W]),
        .re      (perm_re),
        .rd_addr (perm_raddr),
        .rd_data (perm_rdata)
    );

    gn3_ram #(
        .WIDTH (3 * GRAD_W),
        .DEPTH (TABLE_SIZE)
    ) u_grad_ram (
        .clk     (clk),
        .we      (cmd.grad_we),
        .wr_addr (tbl_waddr),
        .wr_data (in_data[GX_OFS +: 3 * GRAD_W]),
        .re      (cmd.op == CMD_GADDR),
        .rd_addr (grad_raddr),
        .rd_data (grad_rdata)
    );

    assign shx = cx_reg >>> k_reg;
    assign shy = cy_reg >>> k_reg;
    assign shz = cz_reg >>> k_reg;

    always_comb
    begin
        perm_re = (cmd.op == CMD_PERM) && (cmd.step < PERM_LAST);
        case (cmd.step)
            3'd0:    perm_raddr = x0_reg;
            3'd1:    perm_raddr = x0_reg + IDX_W'(1);
            3'd2:    perm_raddr = hi_reg + y0_reg;
            3'd3:    perm_raddr = hj_reg + y0_reg;
            3'd4:    perm_raddr = hi_reg + y0_reg + IDX_W'(1);
            3'd5:    perm_raddr = hj_reg + y0_reg + IDX_W'(1);
            default: perm_raddr = x0_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.corner[1:0])
            2'd0:    hsel = h00_reg;
            2'd1:    hsel = h10_reg;
            2'd2:    hsel = h01_reg;
            default: hsel = h11_reg;
        endcase
        zsel       = cmd.corner[2] ? z0_reg + IDX_W'(1) : z0_reg;
        grad_raddr = hsel + zsel;
    end

    assign rx = {cmd.corner[0], fx_reg};
    assign ry = {cmd.corner[1], fy_reg};
    assign rz = {cmd.corner[2], fz_reg};

    always_comb
    begin
        case (cmd.step[2:1])
            2'd0:    fsel = fx_reg;
            2'd1:    fsel = fy_reg;
            default: fsel = fz_reg;
        endcase
        case (cmd.level)
            2'd0:    ssel = sx_reg;
            2'd1:    ssel = sy_reg;
            default: ssel = sz_reg;
        endcase
    end

    assign poly = POLY_W'(FADE_THREE) - POLY_W'({fsel, 1'b0});
    assign diff = DIFF_W'(st_reg[0]) - DIFF_W'(st_reg[1]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            CMD_FADE:
            begin
                if (!cmd.step[0])
                begin
                    mul_a = MUL_A_W'({1'b0, fsel});
                    mul_b = MUL_B_W'({1'b0, fsel});
                end
                else
                begin
                    mul_a = {1'b0, prod_reg[2*FRAC_W-1:0]};
                    mul_b = MUL_B_W'({1'b0, poly});
                end
            end
            CMD_DOT:
            begin
                case (cmd.step[1:0])
                    2'd0:
                    begin
                        mul_a = MUL_A_W'(rx);
                        mul_b = MUL_B_W'($signed(grad_rdata[0 +: GRAD_W]));
                    end
                    2'd1:
                    begin
                        mul_a = MUL_A_W'(ry);
                        mul_b = MUL_B_W'($signed(grad_rdata[GRAD_W +: GRAD_W]));
                    end
                    default:
                    begin
                        mul_a = MUL_A_W'(rz);
                        mul_b = MUL_B_W'($signed(grad_rdata[2*GRAD_W +: GRAD_W]));
                    end
                endcase
            end
            CMD_LERP:
            begin
                mul_a = MUL_A_W'(diff);
                mul_b = MUL_B_W'({1'b0, ssel});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign dot_sum  = acc_reg + ACC_W'(prod_reg);
    assign lerp_sum = DIFF_W'(st_reg[1]) + $signed(prod_reg[DIFF_W+15:16]);
    assign sum_sh   = sum_reg >>> top_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_START:
            begin
                cx_reg  <= $signed(in_data[CX_OFS +: COORD_W]);
                cy_reg  <= $signed(in_data[CY_OFS +: COORD_W]);
                cz_reg  <= $signed(in_data[CZ_OFS +: COORD_W]);
                k_reg   <= cfg.turb ? cfg.top : '0;
                top_reg <= cfg.turb ? cfg.top : '0;
                sum_reg <= '0;
            end
            CMD_SPLIT:
            begin
                x0_reg <= shx[FRAC_W +: IDX_W];
                y0_reg <= shy[FRAC_W +: IDX_W];
                z0_reg <= shz[FRAC_W +: IDX_W];
                fx_reg <= shx[FRAC_W-1:0];
                fy_reg <= shy[FRAC_W-1:0];
                fz_reg <= shz[FRAC_W-1:0];
            end
            CMD_PERM:
            begin
                case (cmd.step)
                    3'd1:    hi_reg  <= perm_idx;
                    3'd2:    hj_reg  <= perm_idx;
                    3'd3:    h00_reg <= perm_idx;
                    3'd4:    h10_reg <= perm_idx;
                    3'd5:    h01_reg <= perm_idx;
                    3'd6:    h11_reg <= perm_idx;
                    default: hi_reg  <= hi_reg;
                endcase
            end
            CMD_FADE:
            begin
                if (!cmd.step[0])
                begin
                    prod_reg <= mul_p;
                end
                else
                begin
                    case (cmd.step[2:1])
                        2'd0:    sx_reg <= mul_p[47:32];
                        2'd1:    sy_reg <= mul_p[47:32];
                        default: sz_reg <= mul_p[47:32];
                    endcase
                end
            end
            CMD_DOT:
            begin
                prod_reg <= mul_p;
                case (cmd.step[1:0])
                    2'd0:    acc_reg <= '0;
                    2'd1:    acc_reg <= ACC_W'(prod_reg);
                    2'd2:    acc_reg <= dot_sum;
                    default:
                    begin
                        st_reg[0] <= dot_sum[ACC_W-1:15];
                        st_reg[1] <= st_reg[0];
                        st_reg[2] <= st_reg[1];
                        st_reg[3] <= st_reg[2];
                    end
                endcase
            end
            CMD_LERP:
            begin
                if (!cmd.step[0])
                begin
                    prod_reg <= mul_p;
                end
                else
                begin
                    st_reg[0] <= lerp_sum[DOT_W-1:0];
                    st_reg[1] <= st_reg[2];
                    st_reg[2] <= st_reg[3];
                end
            end
            CMD_ACC:
            begin
                sum_reg <= sum_reg + (SUM_W'(st_reg[0]) <<< k_reg);
                if (k_reg != '0)
                begin
                    k_reg <= k_reg - SHIFT_W'(1);
                end
            end
            CMD_OUT:
            begin
                if (sum_sh > SAT_HI)
                begin
                    out_reg <= SAT_HI[NOISE_W-1:0];
                end
                else if (sum_sh < SAT_LO)
                begin
                    out_reg <= SAT_LO[NOISE_W-1:0];
                end
                else
                begin
                    out_reg <= sum_sh[NOISE_W-1:0];
                end
            end
            default:
            begin
                out_reg <= out_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == CMD_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_data           = OUT_DATA_W'(out_reg);
    assign status.last_octave = (k_reg == '0);
    assign status.out_free    = !out_valid_reg || out_ready;

endmodule

FILE: hw/rtl/gradient_noise_3d.sv
// Top level of the 3D gradient noise block.
//
// The slave stream carries load and evaluate words; tuser holds the operation.
// Load words write one permutation or gradient table entry and give no
// result. An evaluate word returns one saturated Q3.16 noise word.
// The configuration channel writes the turbulence mode and the top octave
// shift; it is always ready. The user must write it only while the block is
// idle; the block itself does not enforce this. An evaluation runs each octave
// as a split step, the 6 permutation reads, 6 fade multiplies, a gradient
// read and dot product per corner, the 7 blends and an accumulate step, all
// on one shared multiplier and one read port per table. Turbulence runs
// top_octave_shift + 1 octaves. The next word is taken once the result has
// been written to the output register. Only one evaluation is in work at a
// time. A stalled receiver holds the result in the output register, and a
// following evaluation waits at its end until the register frees. Reset
// clears the control state and sets the registers to single noise and
// shift 5; the table contents stay undefined until loaded.
module gradient_noise_3d
    import gn3_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // table_index, perm_value, grad_x, grad_y, grad_z, coord_x, coord_y, coord_z
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // noise_value, then zero padding
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [SHIFT_W-1:0]    cfg_data
);

    cfg_t       cfg_reg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.turb <= 1'b0;
            cfg_reg.top  <= SHIFT_W'(5);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TURB: cfg_reg.turb <= cfg_data[0];
                CFG_TOP:  cfg_reg.top  <= cfg_data;
                default:  cfg_reg.top  <= cfg_reg.top;
            endcase
        end
    end

    gn3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_user  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gn3_dpath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg_reg),
        .in_data   (s_axis_tdata),
        .out_data  (m_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    a_eval_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_EVAL) |=> !s_axis_tready)
        else $error("input taken while an evaluation is in work");

    a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.op == CMD_OUT))
        else $error("result word appeared without a result step");

    a_load_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.perm_we || cmd.grad_we) |-> cmd.op != CMD_START)
        else $error("load word started an evaluation");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CMD_OUT) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pending result overwritten");

endmodule
